>>> src/cht_pkg.sv
package cht_pkg;

    localparam int BUCKETS_DEF     = 256;
    localparam int POOL_DEPTH_DEF  = 64;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int KEY_W  = 64;
    localparam int VAL_W  = 32;
    localparam int CFG_W  = 9;
    localparam int HASH_W = 32;

    localparam int HASH_SH0 = 18;
    localparam int HASH_SH1 = 31;
    localparam int HASH_SH3 = 11;
    localparam int HASH_SH4 = 6;
    localparam int HASH_SH5 = 22;
    localparam logic [2:0] HASH_STEPS = 3'd6;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_LOOKUP = 2'd1;
    localparam logic [1:0] MODE_DELETE = 2'd2;
    localparam logic [1:0] MODE_RSVD   = 2'd3;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND  = 3'd1;
    localparam logic [2:0] ST_DUPLICATE  = 3'd2;
    localparam logic [2:0] ST_POOL_FULL  = 3'd3;
    localparam logic [2:0] ST_ZERO_VALUE = 3'd4;

    typedef struct packed {
        logic [1:0]       mode;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic [VAL_W-1:0] value_out;
        logic [2:0]       status;
    } t_rsp;

    // one round of the 64-to-32 shift hash
    function automatic logic [KEY_W-1:0] hash_step(input logic [KEY_W-1:0] k,
                                                  input logic [2:0] step);
        logic [KEY_W-1:0] r;
        case (step)
            3'd0:    r = (~k) + (k << HASH_SH0);
            3'd1:    r = k ^ (k >> HASH_SH1);
            3'd2:    r = k + (k << 2) + (k << 4);  // times 21
            3'd3:    r = k ^ (k >> HASH_SH3);
            3'd4:    r = k + (k << HASH_SH4);
            3'd5:    r = k ^ (k >> HASH_SH5);
            default: r = k;
        endcase
        return r;
    endfunction

endpackage

>>> src/chained_hash_table_u64.sv
// channel   dir  handshake            word
// request   in   start & !busy        i_req  {mode, key, value}
// result    out  o_valid, one cycle   o_rsp  {value_out, status}
// config    in   i_cfg_we             i_cfg_wdata (bucket_count)
//
// Front end: the hash rounds, then a remainder over the 32 hash bits (2 bits a
// cycle), then a push into a 2-word queue; the back end walks the chain, one
// registered memory read per node, plus a pool allocation or head move where
// needed. The front end takes no new request until its push is done while the
// queue has room; long chains fill the queue and hold the front in its push.
// After reset a clearing pass over every bucket holds busy high.
// Results cannot be stalled; o_valid is a single-cycle strobe.
module chained_hash_table_u64 import cht_pkg::*; #(
    parameter int BUCKETS     = BUCKETS_DEF,
    parameter int POOL_DEPTH  = POOL_DEPTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_req             i_req,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    output logic             o_valid,
    output t_rsp             o_rsp
);

    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int DW = $bits(t_req) + BW;

    logic          f_busy, clearing, push, full, q_valid, pop;
    t_req          f_req, q_req;
    logic [BW-1:0] f_bucket, q_bucket;
    logic [DW-1:0] q_data;

    assign busy = f_busy || clearing;

    cht_front #(.BUCKETS(BUCKETS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_start     (start && !busy),
        .i_req       (i_req),
        .o_busy      (f_busy),
        .o_push      (push),
        .o_req       (f_req),
        .o_bucket    (f_bucket),
        .i_full      (full)
    );

    cht_queue #(.DW(DW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_bucket, f_req}),
        .o_full  (full),
        .o_valid (q_valid),
        .o_data  (q_data),
        .i_pop   (pop)
    );

    assign q_req    = t_req'(q_data[$bits(t_req)-1:0]);
    assign q_bucket = q_data[DW-1:$bits(t_req)];

    cht_back #(
        .BUCKETS     (BUCKETS),
        .POOL_DEPTH  (POOL_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_req    (q_req),
        .i_q_bucket (q_bucket),
        .o_pop      (pop),
        .o_clearing (clearing),
        .o_valid    (o_valid),
        .o_rsp      (o_rsp)
    );

endmodule

>>> src/cht_front.sv
module cht_front import cht_pkg::*; #(
    parameter int BUCKETS = BUCKETS_DEF,
    localparam int BW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1,
    localparam int BCW = $clog2(BUCKETS + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  logic             i_start,
    input  t_req             i_req,
    output logic             o_busy,
    output logic             o_push,
    output t_req             o_req,
    output logic [BW-1:0]    o_bucket,
    input  logic             i_full
);

    typedef enum logic [1:0] {F_IDLE, F_HASH, F_MOD, F_PUSH} t_fstate;

    t_fstate          r_state, n_state;
    logic [2:0]       r_step, n_step;
    logic [3:0]       r_cnt, n_cnt;
    logic [KEY_W-1:0] r_h, n_h;
    logic [BCW-1:0]   r_rem, n_rem;
    logic [BCW-1:0]   r_bc;
    t_req             r_req, n_req;
    logic [BCW:0]     t;
    logic [BCW-1:0]   rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bc <= BCW'(BUCKETS);
        end else if (i_cfg_we) begin
            if (i_cfg_wdata == '0) r_bc <= BCW'(1);
            else if (32'(i_cfg_wdata) > BUCKETS) r_bc <= BCW'(BUCKETS);
            else r_bc <= BCW'(i_cfg_wdata);
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_cnt   = r_cnt;
        n_h     = r_h;
        n_rem   = r_rem;
        n_req   = r_req;
        rem     = r_rem;
        t       = '0;
        case (r_state)
            F_IDLE: begin
                if (i_start) begin
                    n_req   = i_req;
                    n_h     = i_req.key;
                    n_step  = '0;
                    n_state = F_HASH;
                end
            end
            F_HASH: begin
                n_h    = hash_step(r_h, r_step);
                n_step = r_step + 3'd1;
                if (n_step == HASH_STEPS) begin
                    n_h     = {n_h[HASH_W-1:0], {(KEY_W-HASH_W){1'b0}}};
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_state = F_MOD;
                end
            end
            F_MOD: begin
                // restoring remainder, two hash bits a cycle, MSB first
                for (int i = 0; i < 2; i++) begin
                    t = {rem, r_h[KEY_W-1-i]};
                    if (t >= {1'b0, r_bc}) t = t - {1'b0, r_bc};
                    rem = t[BCW-1:0];
                end
                n_rem = rem;
                n_h   = r_h << 2;
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'd15) n_state = F_PUSH;
            end
            F_PUSH: begin
                if (!i_full) n_state = F_IDLE;
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_step <= n_step;
        r_cnt  <= n_cnt;
        r_h    <= n_h;
        r_rem  <= n_rem;
        r_req  <= n_req;
    end

    assign o_busy   = (r_state != F_IDLE);
    assign o_push   = (r_state == F_PUSH) && !i_full;
    assign o_req    = r_req;
    assign o_bucket = BW'(r_rem);

endmodule

>>> src/cht_queue.sv
module cht_queue #(
    parameter int DW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [DW-1:0] i_data,
    output logic          o_full,
    output logic          o_valid,
    output logic [DW-1:0] o_data,
    input  logic          i_pop
);

    logic [DW-1:0] r_mem [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
        if (i_push) r_mem[r_wp] <= i_data;
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

endmodule

>>> src/cht_back.sv
module cht_back import cht_pkg::*; #(
    parameter int BUCKETS     = BUCKETS_DEF,
    parameter int POOL_DEPTH  = POOL_DEPTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    localparam int BW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1,
    localparam int LW  = $clog2(POOL_DEPTH + 1),
    localparam int PW  = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1,
    localparam int VW  = VALUE_WIDTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  t_req          i_q_req,
    input  logic [BW-1:0] i_q_bucket,
    output logic          o_pop,
    output logic          o_clearing,
    output logic          o_valid,
    output t_rsp          o_rsp
);

    typedef enum logic [2:0] {
        S_CLR, S_IDLE, S_HEAD, S_WALK, S_DO, S_HDEL, S_ALLOC, S_LINK
    } t_bstate;

    logic [KEY_W-1:0] hk_mem [BUCKETS];
    logic [VW-1:0]    hv_mem [BUCKETS];
    logic [LW-1:0]    hl_mem [BUCKETS];
    logic [KEY_W-1:0] pk_mem [POOL_DEPTH];
    logic [VW-1:0]    pv_mem [POOL_DEPTH];
    logic [LW-1:0]    pl_mem [POOL_DEPTH];
    logic [PW-1:0]    fs_mem [POOL_DEPTH];

    logic [KEY_W-1:0] r_hk_rd, r_pk_rd;
    logic [VW-1:0]    r_hv_rd, r_pv_rd;
    logic [LW-1:0]    r_hl_rd, r_pl_rd;
    logic [PW-1:0]    r_fs_rd;

    t_bstate        r_state, n_state;
    logic [BW-1:0]  r_cnt, n_cnt;
    logic [BW-1:0]  r_b, n_b;
    t_req           r_req, n_req;
    logic [VW-1:0]  r_val, n_val;
    logic [LW-1:0]  r_node, n_node, r_prev, n_prev, r_link, n_link;
    logic [VW-1:0]  r_cur_val, n_cur_val;
    logic           r_found, n_found, r_hv_nz, n_hv_nz;
    logic [LW:0]    r_fc, n_fc, r_low, n_low;
    logic           r_fs_dflt, n_fs_dflt;
    logic [PW-1:0]  r_fs_pos, n_fs_pos, r_idx, n_idx;
    logic           n_done;
    t_rsp           n_rsp;

    logic [BW-1:0]    h_raddr, h_waddr;
    logic             h_we_kv, h_we_l;
    logic [KEY_W-1:0] h_wk;
    logic [VW-1:0]    h_wv;
    logic [LW-1:0]    h_wl;
    logic [PW-1:0]    p_raddr, p_widx, p_lidx;
    logic             p_we_kv, p_we_l;
    logic [LW-1:0]    p_wl;
    logic [PW-1:0]    fs_raddr, fs_waddr, fs_wdata;
    logic             fs_we;
    logic [LW-1:0]    lk;
    logic [PW-1:0]    idx;

    // links outside 1..POOL_DEPTH end the chain
    function automatic logic [LW-1:0] norm(input logic [LW-1:0] l);
        return (l != '0 && 32'(l) <= POOL_DEPTH) ? l : '0;
    endfunction

    function automatic logic [PW-1:0] to_idx(input logic [LW-1:0] l);
        return PW'(l - LW'(1));
    endfunction

    always_comb begin
        n_state = r_state;  n_cnt = r_cnt;   n_b = r_b;       n_req = r_req;
        n_val = r_val;      n_node = r_node; n_prev = r_prev; n_link = r_link;
        n_cur_val = r_cur_val; n_found = r_found; n_hv_nz = r_hv_nz;
        n_fc = r_fc;        n_low = r_low;   n_fs_dflt = r_fs_dflt;
        n_fs_pos = r_fs_pos; n_idx = r_idx;
        n_done = 1'b0;
        n_rsp  = '{value_out: '0, status: ST_NOT_FOUND};
        o_pop  = 1'b0;
        h_raddr = r_b;  h_waddr = r_b;  h_we_kv = 1'b0;  h_we_l = 1'b0;
        h_wk = r_req.key;  h_wv = r_val;  h_wl = '0;
        p_raddr = '0;  p_widx = '0;  p_lidx = '0;  p_we_kv = 1'b0;  p_we_l = 1'b0;
        p_wl = '0;
        fs_raddr = '0;  fs_waddr = PW'(r_fc);  fs_wdata = '0;  fs_we = 1'b0;
        lk  = '0;
        idx = '0;
        case (r_state)
            S_CLR: begin
                h_waddr = r_cnt;
                h_we_kv = 1'b1;
                h_we_l  = 1'b1;
                h_wk    = '0;
                h_wv    = '0;
                n_cnt   = r_cnt + BW'(1);
                if (r_cnt == BW'(BUCKETS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                h_raddr = i_q_bucket;
                if (i_q_valid) begin
                    o_pop   = 1'b1;
                    n_req   = i_q_req;
                    n_val   = VW'(i_q_req.value);
                    n_b     = i_q_bucket;
                    n_state = S_HEAD;
                end
            end
            S_HEAD: begin
                lk        = norm(r_hl_rd);
                n_hv_nz   = (r_hv_rd != '0);
                n_node    = '0;
                n_prev    = '0;
                n_link    = lk;
                n_cur_val = r_hv_rd;
                n_found   = 1'b0;
                p_raddr   = to_idx(lk);
                if (r_hv_rd != '0 && r_hk_rd == r_req.key) begin
                    n_found = 1'b1;
                    n_state = S_DO;
                end else if (r_hv_rd == '0 || lk == '0) begin
                    n_state = S_DO;
                end else begin
                    n_node  = lk;
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                lk        = norm(r_pl_rd);
                n_link    = lk;
                n_cur_val = r_pv_rd;
                p_raddr   = to_idx(lk);
                if (r_pv_rd != '0 && r_pk_rd == r_req.key) begin
                    n_found = 1'b1;
                    n_state = S_DO;
                end else if (lk == '0) begin
                    n_state = S_DO;
                end else begin
                    n_prev = r_node;
                    n_node = lk;
                end
            end
            S_DO: begin
                n_state  = S_IDLE;
                n_done   = 1'b1;
                p_raddr  = to_idx(r_link);
                fs_raddr = PW'(r_fc - (LW+1)'(1));
                case (r_req.mode)
                    MODE_INSERT: begin
                        if (r_val == '0) begin
                            n_rsp.status = ST_ZERO_VALUE;
                        end else if (r_found) begin
                            n_rsp.status = ST_DUPLICATE;
                        end else if (!r_hv_nz) begin
                            h_we_kv = 1'b1;
                            h_we_l  = 1'b1;
                            n_rsp.status = ST_OK;
                        end else if (r_fc == '0) begin
                            n_rsp.status = ST_POOL_FULL;
                        end else begin
                            // stack slots below the low mark were never written; their position is the index
                            n_fs_pos  = PW'(r_fc - (LW+1)'(1));
                            n_fs_dflt = (r_fc - (LW+1)'(1)) < r_low;
                            n_done    = 1'b0;
                            n_state   = S_ALLOC;
                        end
                    end
                    MODE_LOOKUP: begin
                        if (r_found) begin
                            n_rsp = '{value_out: VAL_W'(r_cur_val), status: ST_OK};
                        end
                    end
                    MODE_DELETE: begin
                        if (r_found) begin
                            n_rsp = '{value_out: VAL_W'(r_cur_val), status: ST_OK};
                            if (r_node == '0) begin
                                if (r_link == '0) begin
                                    h_we_kv = 1'b1;
                                    h_we_l  = 1'b1;
                                    h_wk    = '0;
                                    h_wv    = '0;
                                end else begin
                                    n_done  = 1'b0;
                                    n_state = S_HDEL;
                                end
                            end else begin
                                if (r_prev == '0) begin
                                    h_we_l = 1'b1;
                                    h_wl   = r_link;
                                end else begin
                                    p_we_l = 1'b1;
                                    p_lidx = to_idx(r_prev);
                                    p_wl   = r_link;
                                end
                                if (32'(r_fc) < POOL_DEPTH) begin
                                    fs_we    = 1'b1;
                                    fs_wdata = to_idx(r_node);
                                    n_fc     = r_fc + (LW+1)'(1);
                                end
                            end
                        end
                    end
                    default: ;
                endcase
            end
            S_HDEL: begin
                // successor moves up into the head, its pool slot is freed
                h_we_kv = 1'b1;
                h_we_l  = 1'b1;
                h_wk    = r_pk_rd;
                h_wv    = r_pv_rd;
                h_wl    = norm(r_pl_rd);
                if (32'(r_fc) < POOL_DEPTH) begin
                    fs_we    = 1'b1;
                    fs_wdata = to_idx(r_link);
                    n_fc     = r_fc + (LW+1)'(1);
                end
                n_rsp   = '{value_out: VAL_W'(r_cur_val), status: ST_OK};
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            S_ALLOC: begin
                idx     = r_fs_dflt ? r_fs_pos : r_fs_rd;
                n_idx   = idx;
                n_fc    = r_fc - (LW+1)'(1);
                if (n_fc < r_low) n_low = n_fc;
                p_we_kv = 1'b1;
                p_widx  = idx;
                p_we_l  = 1'b1;
                p_lidx  = idx;
                p_wl    = '0;
                if (r_node == '0) begin
                    h_we_l  = 1'b1;
                    h_wl    = LW'(idx) + LW'(1);
                    n_rsp.status = ST_OK;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_LINK;
                end
            end
            S_LINK: begin
                p_we_l  = 1'b1;
                p_lidx  = to_idx(r_node);
                p_wl    = LW'(r_idx) + LW'(1);
                n_rsp.status = ST_OK;
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_cnt   <= '0;
            r_fc    <= (LW+1)'(POOL_DEPTH);
            r_low   <= (LW+1)'(POOL_DEPTH);
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_fc    <= n_fc;
            r_low   <= n_low;
            o_valid <= n_done;
        end
        r_b <= n_b;  r_req <= n_req;  r_val <= n_val;
        r_node <= n_node;  r_prev <= n_prev;  r_link <= n_link;
        r_cur_val <= n_cur_val;  r_found <= n_found;  r_hv_nz <= n_hv_nz;
        r_fs_dflt <= n_fs_dflt;  r_fs_pos <= n_fs_pos;  r_idx <= n_idx;
        o_rsp <= n_rsp;
    end

    always_ff @(posedge i_clk) begin
        r_hk_rd <= hk_mem[h_raddr];
        r_hv_rd <= hv_mem[h_raddr];
        r_hl_rd <= hl_mem[h_raddr];
        if (h_we_kv) begin
            hk_mem[h_waddr] <= h_wk;
            hv_mem[h_waddr] <= h_wv;
        end
        if (h_we_l) hl_mem[h_waddr] <= h_wl;
    end

    always_ff @(posedge i_clk) begin
        r_pk_rd <= pk_mem[p_raddr];
        r_pv_rd <= pv_mem[p_raddr];
        r_pl_rd <= pl_mem[p_raddr];
        if (p_we_kv) begin
            pk_mem[p_widx] <= r_req.key;
            pv_mem[p_widx] <= r_val;
        end
        if (p_we_l) pl_mem[p_lidx] <= p_wl;
    end

    always_ff @(posedge i_clk) begin
        r_fs_rd <= fs_mem[fs_raddr];
        if (fs_we) fs_mem[fs_waddr] <= fs_wdata;
    end

    assign o_clearing = (r_state == S_CLR);

    a_fc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fc) <= POOL_DEPTH && r_low <= r_fc + (LW+1)'(1))
        else $error("free count out of range");
    a_one_shot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held");
    a_no_rsp_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |-> !o_valid)
        else $error("result during clearing pass");
    a_nf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.status != ST_OK) |-> (o_rsp.value_out == '0))
        else $error("value on failed request");

endmodule
